@@ src/rmst_pkg.sv @@
`default_nettype none
package rmst_pkg;

  localparam int IDX_W      = 10;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 11;
  localparam int DEPTH_DEF  = 1024;
  localparam int DATA_W_DEF = 32;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [0:0] {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QCHK,
    ST_QKEY,
    ST_TRD,
    ST_VRD,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ src/rmst_ifs.sv @@
`default_nettype none
interface rmst_in_if;
  import rmst_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  idx_t  write_index;
  val_t  write_value;
  idx_t  query_low;
  idx_t  query_high;
  modport source (output valid, mode, write_index, write_value, query_low, query_high,
                  input ready);
  modport sink   (input valid, mode, write_index, write_value, query_low, query_high,
                  output ready);
endinterface

interface rmst_out_if;
  import rmst_pkg::*;
  logic valid;
  logic ready;
  idx_t min_position;
  logic out_of_range;
  modport source (output valid, min_position, out_of_range, input ready);
  modport sink   (input valid, min_position, out_of_range, output ready);
endinterface

interface rmst_cfg_if;
  import rmst_pkg::*;
  logic valid;
  logic ready;
  cnt_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ src/range_min_sparse_table_core.sv @@
// Range-minimum engine over a store of signed values, with a sparse table
// of minimum positions rebuilt on demand.
//
// Channels (valid/ready, a transaction moves when both are high):
//   in_chan  : mode 0 writes write_value at write_index (no result);
//              mode 1 queries [query_low, query_high] (one result).
//   out_chan : min_position (leftmost minimum) and out_of_range.
//   cfg_chan : element_count; write only while the block is idle.
// A write is stored as it is accepted. A query on a current table runs
//   through range check, window key, table read, value read, compare and
//   output load, from accept to result. The table and value memories are
//   read through registered ports, which sets that chain.
// After any in-range write or count change the next valid query first rebuilds the
//   table: each entry of each level goes through table read, value read and
//   compare, all through the one compare unit.
// One query is in flight at a time; in_chan.ready is low while it works.
// Reset: count 1, table stale, output empty. Store contents are undefined
//   until written; no clearing pass runs.
// If out_chan stalls, the finished result waits in the output register and
//   a further query holds in its last state until that register frees.
`default_nettype none
module range_min_sparse_table_core #(
  parameter int DEPTH  = rmst_pkg::DEPTH_DEF,
  parameter int DATA_W = rmst_pkg::DATA_W_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rmst_in_if.sink    in_chan,
  rmst_out_if.source out_chan,
  rmst_cfg_if.sink   cfg_chan
);
  import rmst_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NLEV  = AW + 1;
  localparam int LVW   = $clog2(NLEV);
  localparam int EW0   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int EW    = (EW0 > CW) ? EW0 : CW;
  localparam int SW    = CW + 2;
  localparam int XW    = (DATA_W > VAL_W) ? DATA_W : VAL_W;
  localparam int TSIZE = 1 << (LVW + AW);

  // control state
  state_t         state_r, state_nxt;
  logic           stale_r, stale_nxt;
  cnt_t           count_r;
  logic           bld_r, bld_nxt;
  logic [LVW-1:0] lev_r, lev_nxt;
  logic [AW-1:0]  half_r, half_nxt;
  logic [AW-1:0]  i_r, i_nxt;
  logic           out_valid_r, out_valid_nxt;

  // payload
  idx_t           qlo_r, qhi_r;
  logic [LVW-1:0] k_r, k_nxt;
  logic [AW-1:0]  r_r, r_nxt;
  logic           ident_r, ident_nxt;
  logic [AW-1:0]  ia_r, ia_nxt, ib_r, ib_nxt;
  logic [AW-1:0]  pa_r, pa_nxt, pb_r, pb_nxt;
  idx_t           res_pos_r, res_pos_nxt;
  logic           res_oor_r, res_oor_nxt;
  idx_t           out_pos_r;
  logic           out_oor_r;

  // memories
  logic [DATA_W-1:0] vmem [DEPTH];
  logic [AW-1:0]     tmem [TSIZE];
  logic [DATA_W-1:0] va_q, vb_q;
  logic [AW-1:0]     ta_q, tb_q;
  logic [AW-1:0]     va_addr, vb_addr;
  logic [LVW+AW-1:0] ta_addr, tb_addr, tw_addr;
  logic              tmem_we;
  logic [AW-1:0]     tw_data;

  logic              in_acc, wr_acc, wr_ok;
  logic [CW-1:0]     n_eff;
  logic [AW-1:0]     lo_a, hi_a, diff;
  logic [LVW-1:0]    k_calc;
  logic [AW:0]       r_wide;
  logic [XW-1:0]     wv_ext;
  logic [DATA_W-1:0] wkey;
  logic              a_wins;
  logic [AW-1:0]     win;
  logic              out_free;

  assign n_eff = (EW'(count_r) > EW'(DEPTH)) ? CW'(DEPTH) : CW'(count_r);

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc = in_chan.valid && in_chan.ready;
  assign wr_acc = in_acc && (in_chan.mode == MODE_WRITE);
  assign wr_ok  = EW'(in_chan.write_index) < EW'(DEPTH);

  // order-preserving key: flip the sign bit
  assign wv_ext = XW'(in_chan.write_value);
  assign wkey   = wv_ext[DATA_W-1:0] ^ {1'b1, {(DATA_W-1){1'b0}}};

  assign out_chan.valid        = out_valid_r;
  assign out_chan.min_position = out_pos_r;
  assign out_chan.out_of_range = out_oor_r;
  assign out_free = !out_valid_r || out_chan.ready;

  // query window: k = floor(log2(hi - lo)), right start = hi + 1 - 2^k
  assign lo_a = AW'(EW'(qlo_r));
  assign hi_a = AW'(EW'(qhi_r));
  assign diff = hi_a - lo_a;
  always_comb begin
    k_calc = '0;
    for (int j = 1; j < AW; j++) begin
      if (diff[j]) k_calc = LVW'(j);
    end
  end
  assign r_wide = (AW+1)'(hi_a) + (AW+1)'(1) - ((AW+1)'(1) << k_calc);

  // the shared compare unit; ties go left
  assign a_wins = (va_q <= vb_q);
  assign win    = a_wins ? pa_r : pb_r;

  assign ta_addr = bld_r ? {lev_r - LVW'(1), i_r}  : {k_r, lo_a};
  assign tb_addr = bld_r ? {lev_r - LVW'(1), i_r + half_r} : {k_r, r_r};
  assign tw_addr = {lev_r, i_r};
  assign tw_data = win;
  assign va_addr = pa_nxt;
  assign vb_addr = pb_nxt;

  always_comb begin
    state_nxt     = state_r;
    stale_nxt     = stale_r;
    bld_nxt       = bld_r;
    lev_nxt       = lev_r;
    half_nxt      = half_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    r_nxt         = r_r;
    ident_nxt     = ident_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    res_pos_nxt   = res_pos_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    tmem_we       = 1'b0;

    if (wr_acc && wr_ok) stale_nxt = 1'b1;
    if (cfg_chan.valid && cfg_chan.ready) stale_nxt = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_chan.mode == MODE_QUERY)) state_nxt = ST_QCHK;
      end
      ST_QCHK: begin
        if ((qlo_r > qhi_r) || (EW'(qhi_r) >= EW'(n_eff))) begin
          res_pos_nxt = '0;
          res_oor_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else if (stale_r && (n_eff < CW'(2))) begin
          stale_nxt = 1'b0;
          state_nxt = ST_QKEY;
        end else if (stale_r) begin
          bld_nxt   = 1'b1;
          lev_nxt   = LVW'(1);
          half_nxt  = AW'(1);
          i_nxt     = '0;
          state_nxt = ST_TRD;
        end else begin
          state_nxt = ST_QKEY;
        end
      end
      ST_QKEY: begin
        bld_nxt   = 1'b0;
        k_nxt     = k_calc;
        r_nxt     = r_wide[AW-1:0];
        state_nxt = ST_TRD;
      end
      ST_TRD: begin
        // table reads issue here, data lands in VRD
        ident_nxt = bld_r ? (lev_r == LVW'(1)) : (k_r == '0);
        ia_nxt    = bld_r ? i_r : lo_a;
        ib_nxt    = bld_r ? (i_r + half_r) : (k_r == '0 ? hi_a : r_r);
        state_nxt = ST_VRD;
      end
      ST_VRD: begin
        pa_nxt    = ident_r ? ia_r : ta_q;
        pb_nxt    = ident_r ? ib_r : tb_q;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (bld_r) begin
          tmem_we = 1'b1;
          if ((SW'(i_r) + (SW'(half_r) << 1)) == SW'(n_eff)) begin
            if ((SW'(half_r) << 2) <= SW'(n_eff)) begin
              lev_nxt   = lev_r + LVW'(1);
              half_nxt  = half_r << 1;
              i_nxt     = '0;
              state_nxt = ST_TRD;
            end else begin
              stale_nxt = 1'b0;
              bld_nxt   = 1'b0;
              state_nxt = ST_QKEY;
            end
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_TRD;
          end
        end else begin
          res_pos_nxt = IDX_W'(EW'(win));
          res_oor_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stale_r     <= 1'b1;
      count_r     <= CNT_W'(1);
      bld_r       <= 1'b0;
      lev_r       <= '0;
      half_r      <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stale_r     <= stale_nxt;
      bld_r       <= bld_nxt;
      lev_r       <= lev_nxt;
      half_r      <= half_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) count_r <= cfg_chan.data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      qlo_r <= in_chan.query_low;
      qhi_r <= in_chan.query_high;
    end
    k_r       <= k_nxt;
    r_r       <= r_nxt;
    ident_r   <= ident_nxt;
    ia_r      <= ia_nxt;
    ib_r      <= ib_nxt;
    pa_r      <= pa_nxt;
    pb_r      <= pb_nxt;
    res_pos_r <= res_pos_nxt;
    res_oor_r <= res_oor_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_pos_r <= res_pos_r;
      out_oor_r <= res_oor_r;
    end
  end

  // value store
  always_ff @(posedge clk) begin
    if (wr_acc && wr_ok) vmem[AW'(EW'(in_chan.write_index))] <= wkey;
    va_q <= vmem[va_addr];
    vb_q <= vmem[vb_addr];
  end

  // sparse table, levels 1 and up
  always_ff @(posedge clk) begin
    if (tmem_we) tmem[tw_addr] <= tw_data;
    ta_q <= tmem[ta_addr];
    tb_q <= tmem[tb_addr];
  end

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.out_of_range |-> out_chan.min_position == '0)
    else $error("out-of-range result with nonzero position");

  a_build_stale: assert property (@(posedge clk) disable iff (!rst_n)
    tmem_we |-> stale_r)
    else $error("table written while current");

  a_write_stale: assert property (@(posedge clk) disable iff (!rst_n)
    wr_acc && wr_ok |=> stale_r)
    else $error("store write did not mark table stale");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.out_of_range |->
      EW'(out_chan.min_position) < EW'(n_eff))
    else $error("result position beyond element count");

endmodule
`default_nettype wire

@@ tb/sv/range_min_sparse_table_core_tb.sv @@
`timescale 1ns / 1ps
module range_min_sparse_table_core_tb;
  import rmst_pkg::*;

  localparam int NSLOT = 1024;

  typedef struct packed {
    mode_t mode;
    idx_t  write_index;
    val_t  write_value;
    idx_t  query_low;
    idx_t  query_high;
  } rmq_req_t;

  typedef struct packed {
    idx_t min_position;
    logic out_of_range;
  } rmq_ans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rmst_in_if  in_chan ();
  rmst_out_if out_chan ();
  rmst_cfg_if cfg_chan ();

  range_min_sparse_table_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source),
    .cfg_chan(cfg_chan.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state of the block.
  val_t       shadow_vals[NSLOT];
  bit         shadow_written[NSLOT];
  int         shadow_count = 1;

  rmq_req_t   pending_reqs[$];
  rmq_ans_t   expected_mins[$];
  int         error_count = 0;
  bit         quiet_phase = 1'b0;   // no idling on either side while set

  // Linear scan gives the same answer as the sparse table: leftmost minimum.
  function automatic rmq_ans_t window_min(idx_t lo, idx_t hi);
    rmq_ans_t a;
    int       n;
    int       best;
    n = (shadow_count > NSLOT) ? NSLOT : shadow_count;
    a.min_position = '0;
    a.out_of_range = 1'b0;
    if (lo > hi || int'(hi) >= n) begin
      a.out_of_range = 1'b1;
      return a;
    end
    best = lo;
    for (int i = lo + 1; i <= hi; i++)
      if (shadow_vals[i] < shadow_vals[best]) best = i;
    a.min_position = idx_t'(best);
    return a;
  endfunction

  // Input transaction seen at the rising edge, before ready can drop.
  bit in_fire = 1'b0;
  always @(posedge clk)
    in_fire <= rst_n && in_chan.valid && in_chan.ready;

  // Input driver: changes at falling edge, transaction seen at rising edge.
  bit       in_busy = 1'b0;
  rmq_req_t in_cur;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_busy && in_fire) in_busy = 1'b0;
      if (!in_busy && pending_reqs.size() > 0 &&
          (quiet_phase || $urandom_range(99) >= 18)) begin
        in_cur  = pending_reqs.pop_front();
        in_busy = 1'b1;
        // prediction on hand-off; order is kept since one item is in flight
        if (in_cur.mode == MODE_WRITE) begin
          shadow_vals[in_cur.write_index]    = in_cur.write_value;
          shadow_written[in_cur.write_index] = 1'b1;
        end else begin
          expected_mins.push_back(window_min(in_cur.query_low, in_cur.query_high));
        end
      end
      in_chan.valid       <= in_busy;
      in_chan.mode        <= in_cur.mode;
      in_chan.write_index <= in_cur.write_index;
      in_chan.write_value <= in_cur.write_value;
      in_chan.query_low   <= in_cur.query_low;
      in_chan.query_high  <= in_cur.query_high;
    end
  end

  always @(negedge clk)
    out_chan.ready <= rst_n && (quiet_phase || $urandom_range(99) >= 18);

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_mins.size() == 0) begin
        $display("%0t: unexpected result pos=%0d oor=%0b", $realtime,
                 out_chan.min_position, out_chan.out_of_range);
        error_count++;
      end else begin
        rmq_ans_t e;
        e = expected_mins.pop_front();
        if (e.min_position !== out_chan.min_position ||
            e.out_of_range !== out_chan.out_of_range) begin
          $display("%0t: mismatch expected pos=%0d oor=%0b actual pos=%0d oor=%0b",
                   $realtime, e.min_position, e.out_of_range,
                   out_chan.min_position, out_chan.out_of_range);
          error_count++;
        end
      end
    end
  end

  task automatic add_write(int idx, val_t v);
    rmq_req_t r;
    r = '0;
    r.mode = MODE_WRITE;
    r.write_index = idx_t'(idx);
    r.write_value = v;
    r.query_low = idx_t'($urandom);
    r.query_high = idx_t'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic add_query(int lo, int hi);
    rmq_req_t r;
    r = '0;
    r.mode = MODE_QUERY;
    r.write_index = idx_t'($urandom);
    r.write_value = val_t'($urandom);
    r.query_low = idx_t'(lo);
    r.query_high = idx_t'(hi);
    pending_reqs.push_back(r);
  endtask

  // Let the block drain before a register write.
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_busy || expected_mins.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_count(int n);
    @(negedge clk);
    cfg_chan.data  <= cnt_t'(n);
    cfg_chan.valid <= 1'b1;
    do @(posedge clk); while (!cfg_chan.ready);
    shadow_count = n;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // Writes every unwritten slot below n and rewrites some others (only written slots get queried), then a mix.
  task automatic random_phase(int n, int items);
    int lo;
    int hi;
    for (int i = 0; i < n; i++)
      if (!shadow_written[i] || $urandom_range(3) == 0)
        add_write(i, ($urandom_range(1)) ? val_t'($urandom) :
                     val_t'($urandom_range(7)) - 3);
    for (int j = 0; j < items; j++) begin
      case ($urandom_range(9))
        0, 1: add_write($urandom_range(n - 1),
                        ($urandom_range(1)) ? val_t'($urandom) :
                        val_t'($urandom_range(3)));
        2: add_query($urandom_range(1023), $urandom_range(1023)); // often bad
        default: begin
          lo = $urandom_range(n - 1);
          hi = lo + $urandom_range(n - 1 - lo);
          add_query(lo, hi);
        end
      endcase
    end
  endtask

  initial begin
    int sizes[6];
    in_chan.valid = 1'b0;
    in_chan.mode = MODE_WRITE;
    in_chan.write_index = '0;
    in_chan.write_value = '0;
    in_chan.query_low = '0;
    in_chan.query_high = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: count 1 after reset, extremes, ties, bad ranges.
    add_write(0, 32'sh8000_0000);
    add_query(0, 0);
    add_query(0, 1);
    add_query(1, 0);
    add_query(1023, 1023);
    wait_idle();
    set_count(0);                         // every query out of range
    add_query(0, 0);
    wait_idle();
    set_count(8);
    add_write(1, 32'sh7FFF_FFFF);
    add_write(2, -5);
    add_write(3, -5);                     // tie, leftmost wins
    for (int i = 4; i < 8; i++) add_write(i, 32'sh7FFF_FFFF);
    add_write(1023, 1);                   // beyond count, never queried
    add_query(1, 7);
    add_query(3, 7);
    add_query(2, 3);
    add_query(7, 7);
    add_query(0, 8);                      // high at count
    add_query(5, 4);                      // low above high
    add_write(0, 32'sh0000_0000);
    add_query(0, 7);                      // stale after write
    wait_idle();

    // Random: a quiet stretch in the middle phase.
    sizes = '{2, 1024, 13, 2047, 5, 64};
    foreach (sizes[s]) begin
      set_count(sizes[s]);
      quiet_phase = (s == 3);
      random_phase((sizes[s] > NSLOT) ? NSLOT : sizes[s],
                   (sizes[s] >= NSLOT) ? 40 : 80);
      wait_idle();
    end
    quiet_phase = 1'b0;

    if (error_count == 0 && expected_mins.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Rebuilds at full depth run through every level of the table; allow plenty.
  initial begin
    #400ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
